[rtl/nfa_bit_track_matcher_top_macros.svh]
// Assertion macros used by the matcher top level.
`ifndef NFA_BIT_TRACK_MATCHER_TOP_MACROS_SVH
`define NFA_BIT_TRACK_MATCHER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define NBTM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nbtm: same-cycle check failed");

// next-cycle implication
`define NBTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nbtm: next-cycle check failed");

`else

`define NBTM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define NBTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/nbtm_pkg.sv]
// Shared types and constants of the bit-track automaton matcher.
package nbtm_pkg;

    localparam int NUM_STATES  = 16;
    localparam int NUM_TRACKS  = 4;
    localparam int STATE_W     = 4;
    localparam int SYM_W       = 4;
    localparam int STATE_CNT_W = 5;
    localparam int TRACK_CNT_W = 3;
    localparam int MASK_W      = 16;
    localparam int ADDR_W      = STATE_W + SYM_W;
    localparam int MEM_DEPTH   = 1 << ADDR_W;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_STEP   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        CFG_TRACK_COUNT = 2'd0,
        CFG_STATE_COUNT = 2'd1,
        CFG_START_MASK  = 2'd2,
        CFG_FINAL_MASK  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDIT,
        ST_WRITE,
        ST_LOAD,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load_item;
        logic edit;
        logic mem_write;
        logic step_load;
        logic walk;
        logic drain;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_rmw;
        logic last;
        logic walk_done;
        logic out_free;
    } t_stat;

endpackage

[rtl/nbtm_ctrl.sv]
// Sequencer for edits and symbol steps of the matcher.
module nbtm_ctrl
    import nbtm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_action,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    unique case (i_action)
                        ACT_ADD, ACT_REMOVE: n_state = ST_EDIT;
                        ACT_STEP:            n_state = ST_LOAD;
                        default:             n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EDIT: begin
                o_cmd.edit = 1'b1;
                n_state    = i_stat.need_rmw ? ST_WRITE : ST_IDLE;
            end
            ST_WRITE: begin
                o_cmd.mem_write = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_LOAD: begin
                o_cmd.step_load = 1'b1;
                n_state         = ST_WALK;
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                o_cmd.drain = 1'b1;
                n_state     = i_stat.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

[rtl/nbtm_datapath.sv]
// Tables, active set, walk registers and result register of the matcher.
module nbtm_datapath
    import nbtm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic [1:0]             i_action,
    input  logic [STATE_W-1:0]     i_from_state,
    input  logic [STATE_W-1:0]     i_to_state,
    input  logic                   i_is_epsilon,
    input  logic [SYM_W-1:0]       i_symbol,
    input  logic                   i_first,
    input  logic                   i_last,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [MASK_W-1:0]      i_cfg_data,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic                   o_accepted,
    output logic [MASK_W-1:0]      o_active_states
);

    // configuration
    logic [TRACK_CNT_W-1:0] r_track_count;
    logic [STATE_CNT_W-1:0] r_state_count;
    logic [MASK_W-1:0]      r_start_mask;
    logic [MASK_W-1:0]      r_final_mask;

    // latched item
    logic [1:0]         r_action;
    logic [STATE_W-1:0] r_from;
    logic [STATE_W-1:0] r_to;
    logic               r_eps;
    logic [SYM_W-1:0]   r_sym;
    logic               r_first;
    logic               r_last;

    // tables
    logic [MASK_W-1:0]    mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_mem_valid;
    logic [MASK_W-1:0]    r_eps_tab [NUM_STATES];
    logic [MASK_W-1:0]    r_rd_data;
    logic                 r_rd_valid;

    // walk
    logic [STATE_W-1:0] r_idx;
    logic [MASK_W-1:0]  r_cur;
    logic [MASK_W-1:0]  r_nxt;
    logic               r_fired;
    logic               r_rd_hit;
    logic [MASK_W-1:0]  r_active;

    // result
    logic              r_out_valid;
    logic              r_out_acc;
    logic [MASK_W-1:0] r_out_set;

    logic [STATE_CNT_W-1:0] w_n_eff;
    logic [MASK_W:0]        w_smask_full;
    logic [MASK_W-1:0]      w_smask;
    logic [SYM_W-1:0]       w_sym_mask;
    logic [SYM_W-1:0]       w_sym_step;
    logic                   w_add_ok;
    logic                   w_is_remove;
    logic [MASK_W-1:0]      w_to_bit;
    logic [MASK_W-1:0]      w_old;
    logic [MASK_W-1:0]      w_wr_data;
    logic [ADDR_W-1:0]      w_edit_addr;
    logic [ADDR_W-1:0]      w_rd_addr;
    logic                   w_hit;
    logic [MASK_W-1:0]      w_acc_s;
    logic [MASK_W-1:0]      w_nxt_acc;
    logic                   w_fired_acc;

    always_comb begin
        w_n_eff      = (r_state_count > STATE_CNT_W'(NUM_STATES))
                       ? STATE_CNT_W'(NUM_STATES) : r_state_count;
        w_smask_full = ((MASK_W+1)'(1) << w_n_eff) - (MASK_W+1)'(1);
        w_smask      = w_smask_full[MASK_W-1:0];
        unique case (r_track_count)
            3'd0:    w_sym_mask = 4'h0;
            3'd1:    w_sym_mask = 4'h1;
            3'd2:    w_sym_mask = 4'h3;
            3'd3:    w_sym_mask = 4'h7;
            default: w_sym_mask = 4'hF;
        endcase
        w_sym_step  = r_sym & w_sym_mask;
        w_is_remove = (r_action == ACT_REMOVE);
        w_add_ok    = ({1'b0, r_from} < w_n_eff) && ({1'b0, r_to} < w_n_eff)
                      && (r_eps || ((r_sym & ~w_sym_mask) == '0));
        w_to_bit    = MASK_W'(1) << r_to;
        w_old       = r_rd_valid ? r_rd_data : '0;
        w_wr_data   = w_is_remove ? (w_old & ~w_to_bit) : (w_old | w_to_bit);
        w_edit_addr = {r_from, r_sym};
        w_rd_addr   = i_cmd.walk ? {r_idx, w_sym_step} : w_edit_addr;

        w_hit       = r_cur[r_idx];
        // labelled successors of the state visited in the previous cycle
        w_acc_s     = (r_rd_valid ? r_rd_data : '0) & w_smask & {MASK_W{r_rd_hit}};
        w_nxt_acc   = r_nxt | w_acc_s;
        w_fired_acc = r_fired | (w_acc_s != '0);
    end

    assign o_stat.need_rmw  = !r_eps && (w_is_remove || w_add_ok);
    assign o_stat.last      = r_last;
    assign o_stat.walk_done = (r_idx == STATE_W'(NUM_STATES - 1));
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_count <= TRACK_CNT_W'(1);
            r_state_count <= STATE_CNT_W'(1);
            r_start_mask  <= MASK_W'(1);
            r_final_mask  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TRACK_COUNT: r_track_count <= i_cfg_data[TRACK_CNT_W-1:0];
                CFG_STATE_COUNT: r_state_count <= i_cfg_data[STATE_CNT_W-1:0];
                CFG_START_MASK:  r_start_mask  <= i_cfg_data;
                CFG_FINAL_MASK:  r_final_mask  <= i_cfg_data;
                default:         r_final_mask  <= r_final_mask;
            endcase
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= i_action;
            r_from   <= i_from_state;
            r_to     <= i_to_state;
            r_eps    <= i_is_epsilon;
            r_sym    <= i_symbol;
            r_first  <= i_first;
            r_last   <= i_last;
        end
    end

    // successor memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            mem[w_edit_addr] <= w_wr_data;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    // per-entry valid bits stand in for the cleared reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_cmd.mem_write) begin
                r_mem_valid[w_edit_addr] <= 1'b1;
            end
            r_rd_valid <= r_mem_valid[w_rd_addr];
        end
    end

    // epsilon table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STATES; k++) begin
                r_eps_tab[k] <= '0;
            end
        end else if (i_cmd.edit && r_eps) begin
            if (w_is_remove) begin
                r_eps_tab[r_from] <= r_eps_tab[r_from] & ~w_to_bit;
            end else if (w_add_ok) begin
                r_eps_tab[r_from] <= r_eps_tab[r_from] | w_to_bit;
            end
        end
    end

    // step walk and active set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_rd_hit <= 1'b0;
            r_fired  <= 1'b0;
            r_idx    <= '0;
        end else if (i_cmd.step_load) begin
            r_cur    <= (r_first ? r_start_mask : r_active) & w_smask;
            r_nxt    <= '0;
            r_fired  <= 1'b0;
            r_idx    <= '0;
            r_rd_hit <= 1'b0;
        end else if (i_cmd.walk) begin
            r_cur    <= r_cur | (w_hit ? (r_eps_tab[r_idx] & w_smask) : '0);
            r_rd_hit <= w_hit;
            r_nxt    <= w_nxt_acc;
            r_fired  <= w_fired_acc;
            r_idx    <= r_idx + STATE_W'(1);
        end else if (i_cmd.drain) begin
            r_active <= w_fired_acc ? w_nxt_acc : r_cur;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_set <= r_active;
            r_out_acc <= (r_active & r_final_mask) != '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_out_acc;
    assign o_active_states = r_out_set;

endmodule

[rtl/nfa_bit_track_matcher_top.sv]
// Top level of the bit-track automaton matcher.
//
// Runs a nondeterministic automaton of up to 16 states over symbols built
// from up to 4 parallel bit tracks. Each input word either edits the
// transition tables (add or remove a labelled or epsilon move) or steps one
// symbol. An epsilon add or remove is done in the edit state; a labelled
// one adds a write state (read-modify-write of the successor memory). A
// step runs through accept, load of the active set, a walk over all 16
// states (one successor-memory read per state, one state per cycle, the
// memory's single read port sets this), and a commit state; a step with
// last set then loads the result register in an emit state, waiting there
// while a previous result is still stalled. Input stall is high for
// the whole time an item is in work. The walk visits states in ascending
// order; an active state ORs its epsilon targets into the set at once, so
// targets above it are visited in the same step. If no labelled move fires
// the set (with epsilon additions) is kept. The successor memory (256
// entries) carries one valid bit per entry, so it reads as cleared right
// after reset with no clearing pass. Configuration writes are taken at any
// time but must only be issued while the block is idle.
module nfa_bit_track_matcher_top
    import nbtm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input word channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [STATE_W-1:0] i_from_state,
    input  logic [STATE_W-1:0] i_to_state,
    input  logic               i_is_epsilon,
    input  logic [SYM_W-1:0]   i_symbol,
    input  logic               i_first,
    input  logic               i_last,
    // result word channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_accepted,
    output logic [MASK_W-1:0]  o_active_states,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [MASK_W-1:0]  i_cfg_data
);

`include "nfa_bit_track_matcher_top_macros.svh"

    t_cmd  w_cmd;
    t_stat w_stat;

    nbtm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    nbtm_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_action        (i_action),
        .i_from_state    (i_from_state),
        .i_to_state      (i_to_state),
        .i_is_epsilon    (i_is_epsilon),
        .i_symbol        (i_symbol),
        .i_first         (i_first),
        .i_last          (i_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_accepted      (o_accepted),
        .o_active_states (o_active_states)
    );

    // at most one datapath command per cycle
    `NBTM_ASSERT_NOW(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(w_cmd))

    // a result is only loaded when the result register can take it
    `NBTM_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, w_cmd.emit, !o_out_valid || !i_out_stall)

    // an accepted edit or step keeps the input side stalled next cycle
    `NBTM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_action == ACT_ADD || i_action == ACT_REMOVE || i_action == ACT_STEP), o_in_stall)

    // loading a result always presents it next cycle
    `NBTM_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, w_cmd.emit, o_out_valid)

endmodule
